FILE: rtl/core/elfr_pkg.sv
// Package for the escaped length frame receiver.
// Widths, byte codes, reset values and the state and result structs.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package elfr_pkg;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 9;
    localparam int IDX_W  = 7;
    localparam int CFG_IDX_W = 1;

    localparam int BUFFER_DEPTH_DEFAULT = 128;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_BYTE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_BYTE = 1'd1;

    // register reset values
    localparam logic [BYTE_W-1:0] START_BYTE_RESET  = 8'h02;
    localparam logic [BYTE_W-1:0] ESCAPE_BYTE_RESET = 8'h10;

    // unescape codes
    localparam logic [BYTE_W-1:0] UNESC_SRC_A = 8'h0E;
    localparam logic [BYTE_W-1:0] UNESC_SRC_B = 8'h0D;
    localparam logic [BYTE_W-1:0] UNESC_DST_A = ~UNESC_SRC_A;
    localparam logic [BYTE_W-1:0] UNESC_DST_B = ~UNESC_SRC_B;

    // frame layout
    localparam logic [POS_W-1:0] LENGTH_POS  = 9'd4;
    localparam logic [POS_W-1:0] FRAME_EXTRA = 9'd7;

    typedef struct packed {
        logic              receiving;
        logic [POS_W-1:0]  position;
        logic [BYTE_W-1:0] payload_length;
        logic              escape_pending;
    } rx_state_t;

    typedef struct packed {
        logic              store_valid;
        logic [IDX_W-1:0]  store_index;
        logic [BYTE_W-1:0] store_value;
        logic              frame_done;
        logic              overflow;
    } rx_result_t;

endpackage : elfr_pkg

`default_nettype wire

FILE: rtl/core/elfr_if.sv
// Channel interfaces for the escaped length frame receiver.
// Byte input, result output and configuration write channels.
// Depends on elfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface elfr_rx_if import elfr_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface : elfr_rx_if

interface elfr_res_if import elfr_pkg::*;;
    logic              valid;
    logic              ready;
    logic              store_valid;
    logic [IDX_W-1:0]  store_index;
    logic [BYTE_W-1:0] store_value;
    logic              frame_done;
    logic              overflow;

    modport source (output valid, output store_valid, output store_index,
                    output store_value, output frame_done, output overflow,
                    input ready);
    modport sink   (input valid, input store_valid, input store_index,
                    input store_value, input frame_done, input overflow,
                    output ready);
endinterface : elfr_res_if

interface elfr_cfg_if import elfr_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [BYTE_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface : elfr_cfg_if

`default_nettype wire

FILE: rtl/core/elfr_step.sv
// Per-byte decode of the frame receiver: next state and result for one item.
// Pure combinational logic between the state registers and the result register.
// Depends on elfr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module elfr_step
    import elfr_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT
)
(
    input  wire rx_state_t         cur,
    input  wire logic [BYTE_W-1:0] rx_byte,
    input  wire logic [BYTE_W-1:0] start_byte,
    input  wire logic [BYTE_W-1:0] escape_byte,
    output rx_state_t              nxt,
    output rx_result_t             res
);

    localparam logic [POS_W:0] DEPTH_L = (POS_W + 1)'(BUFFER_DEPTH);

    logic              is_escape;
    logic [BYTE_W-1:0] value;
    logic [POS_W-1:0]  pos_inc;
    logic [POS_W-1:0]  frame_end;

    // unescape the incoming byte; escape test comes first
    always_comb
    begin
        is_escape = (rx_byte == escape_byte);
        if (is_escape)
            value = rx_byte;
        else if (cur.escape_pending && rx_byte == UNESC_SRC_A)
            value = UNESC_DST_A;
        else if (cur.escape_pending && rx_byte == UNESC_SRC_B)
            value = UNESC_DST_B;
        else
            value = rx_byte;
    end

    assign pos_inc = cur.position + POS_W'(1);

    // state update and result
    always_comb
    begin
        nxt       = cur;
        res       = '0;
        frame_end = '0;
        if (!cur.receiving)
        begin
            if (rx_byte == start_byte)
            begin
                nxt.receiving      = 1'b1;
                nxt.escape_pending = 1'b0;
                nxt.position       = POS_W'(1);
                res.store_valid    = 1'b1;
                res.store_value    = rx_byte;
            end
        end
        else if ({1'b0, cur.position} >= DEPTH_L)
        begin
            res.overflow       = 1'b1;
            nxt.receiving      = 1'b0;
            nxt.escape_pending = 1'b0;
        end
        else
        begin
            res.store_valid = 1'b1;
            res.store_index = cur.position[IDX_W-1:0];
            res.store_value = value;
            if (cur.position == LENGTH_POS)
                nxt.payload_length = value;
            nxt.escape_pending = is_escape;
            nxt.position       = is_escape ? cur.position : pos_inc;
            frame_end = POS_W'(nxt.payload_length) + FRAME_EXTRA;
            if (nxt.position == frame_end)
            begin
                res.frame_done     = 1'b1;
                nxt.receiving      = 1'b0;
                nxt.escape_pending = 1'b0;
            end
        end
    end

endmodule : elfr_step

`default_nettype wire

FILE: rtl/core/escaped_length_frame_receiver_top.sv
// An accepted byte's result item is loaded into the output register on the following cycle.
// Throughput: one byte per cycle; the frame state register updates on each accepted
// byte and the output register is reloaded in the same cycle it is taken.
// Input ready drops only while a result waits unaccepted in the output register.
// Reset: start byte 0x02, escape byte 0x10, idle, position and length 0, no result held.
// Configuration writes are always ready and take effect on the next byte.
`timescale 1ns / 1ps
`default_nettype none

module escaped_length_frame_receiver_top
    import elfr_pkg::*;
#(
    parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEFAULT
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    elfr_rx_if.sink       rx,
    elfr_res_if.source    res,
    elfr_cfg_if.sink      cfg
);

    rx_state_t         state_reg;
    rx_state_t         state_next;
    rx_result_t        result_reg;
    rx_result_t        result_next;
    logic              out_valid_reg;
    logic [BYTE_W-1:0] start_byte_reg;
    logic [BYTE_W-1:0] escape_byte_reg;
    logic              rx_accept;

    // per-byte decode
    elfr_step #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_step (
        .cur         (state_reg),
        .rx_byte     (rx.rx_byte),
        .start_byte  (start_byte_reg),
        .escape_byte (escape_byte_reg),
        .nxt         (state_next),
        .res         (result_next)
    );

    // handshakes
    assign rx.ready  = !out_valid_reg || res.ready;
    assign rx_accept = rx.valid && rx.ready;
    assign cfg.ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg  <= START_BYTE_RESET;
            escape_byte_reg <= ESCAPE_BYTE_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_START_BYTE:  start_byte_reg  <= cfg.data;
                REG_ESCAPE_BYTE: escape_byte_reg <= cfg.data;
                default:         ;
            endcase
        end
    end

    // frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= '0;
        else if (rx_accept)
            state_reg <= state_next;
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (rx.ready)
            out_valid_reg <= rx.valid;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (rx_accept)
            result_reg <= result_next;
    end

    assign res.valid       = out_valid_reg;
    assign res.store_valid = result_reg.store_valid;
    assign res.store_index = result_reg.store_index;
    assign res.store_value = result_reg.store_value;
    assign res.frame_done  = result_reg.frame_done;
    assign res.overflow    = result_reg.overflow;

    // an overflow item never carries a store
    a_ovf_no_store: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(result_reg.overflow && result_reg.store_valid))
        else $error("overflow item also carries a store");

    // completion only on a stored byte
    a_done_stores: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.frame_done |-> result_reg.store_valid)
        else $error("frame_done without a store");

    // a finished or dropped frame leaves the receiver idle
    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rx_accept && (result_next.frame_done || result_next.overflow)
        |=> !state_reg.receiving)
        else $error("receiver still busy after frame end");

    // no escape is pending while idle
    a_idle_no_escape: assert property (@(posedge clk) disable iff (!rst_n)
        !state_reg.receiving |-> !state_reg.escape_pending)
        else $error("escape pending while idle");

endmodule : escaped_length_frame_receiver_top

`default_nettype wire
